FILE: rtl/core/keyed_slot_table_defines.svh
// ----------------------------------------------------------------------------
// keyed slot table assertion macros
// concurrent assertion shorthands clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef KEYED_SLOT_TABLE_DEFINES_SVH
`define KEYED_SLOT_TABLE_DEFINES_SVH

// same-cycle implication
`define KST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed slot table check failed");

// next-cycle implication
`define KST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed slot table check failed");

`endif

FILE: rtl/core/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// shared types and constants of the keyed slot table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kst_pkg;

    localparam int TABLE_SIZE_DEF  = 32;
    localparam int KEY_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int SLOT_BITS       = 5;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_READ   = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    typedef struct packed {
        logic active;
        logic wr_en;
    } init_t;

endpackage

FILE: rtl/core/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kst_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/kst_init.sv
// ----------------------------------------------------------------------------
// kst_init
// clearing pass after reset, writes every entry as empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kst_init #(
    parameter int TABLE_SIZE = kst_pkg::TABLE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output kst_pkg::init_t                init,
    output logic [$clog2(TABLE_SIZE)-1:0] addr
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

    logic          active_reg;
    logic [AW-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            clr_reg    <= '0;
        end
        else if (active_reg)
        begin
            if (clr_reg == LAST_IDX)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    assign init.active = active_reg;
    assign init.wr_en  = active_reg;
    assign addr        = clr_reg;

endmodule

FILE: rtl/core/kst_engine.sv
// ----------------------------------------------------------------------------
// kst_engine
// request sequencer, scans the table memory with a read-check pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kst_engine #(
    parameter int TABLE_SIZE  = kst_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS    = kst_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = kst_pkg::HANDLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kst_pkg::init_t                     init,
    input  logic                               start,
    input  logic [1:0]                         mode,
    input  logic [KEY_BITS-1:0]                key,
    input  logic [kst_pkg::SLOT_BITS-1:0]      slot_in,
    input  logic [HANDLE_BITS-1:0]             handle_in,
    output logic                               busy,
    output logic                               done,
    output logic                               status,
    output logic [HANDLE_BITS-1:0]             handle_out,
    output logic [kst_pkg::SLOT_BITS-1:0]      slot_out,
    output logic                               rd_en,
    output logic [$clog2(TABLE_SIZE)-1:0]      rd_addr,
    input  logic [KEY_BITS+HANDLE_BITS:0]      rd_data,
    output logic                               wr_en,
    output logic [$clog2(TABLE_SIZE)-1:0]      wr_addr,
    output logic [KEY_BITS+HANDLE_BITS:0]      wr_data
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int EW = KEY_BITS + HANDLE_BITS + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                        state_reg;
    kst_pkg::mode_t                mode_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [HANDLE_BITS-1:0]        hin_reg;
    logic [AW-1:0]                 issue_reg;
    logic                          issue_on_reg;
    logic                          dv_reg;
    logic [AW-1:0]                 didx_reg;
    logic                          hit_reg;
    logic [HANDLE_BITS-1:0]        lh_reg;
    logic [AW-1:0]                 ls_reg;
    logic                          done_reg;
    logic                          status_reg;
    logic [HANDLE_BITS-1:0]        handle_out_reg;
    logic [kst_pkg::SLOT_BITS-1:0] slot_out_reg;

    logic                   e_valid;
    logic [KEY_BITS-1:0]    e_key;
    logic [HANDLE_BITS-1:0] e_handle;
    logic                   e_match;
    logic                   last;
    logic                   issue_stop;
    logic [31:0]            slot_ext;
    logic                   slot_in_range;

    function automatic logic [kst_pkg::SLOT_BITS-1:0] slot5(input logic [AW-1:0] idx);
        logic [31:0] t;
        t = 32'(idx);
        return t[kst_pkg::SLOT_BITS-1:0];
    endfunction

    assign e_valid  = rd_data[EW-1];
    assign e_key    = rd_data[EW-2 -: KEY_BITS];
    assign e_handle = rd_data[HANDLE_BITS-1:0];
    assign e_match  = e_valid && (e_key == key_reg);
    assign last     = (mode_reg == kst_pkg::MODE_READ) || (didx_reg == LAST_IDX);
    assign issue_stop = (issue_reg == LAST_IDX) || (mode_reg == kst_pkg::MODE_READ);

    assign slot_ext      = 32'(slot_in);
    assign slot_in_range = slot_ext < 32'(TABLE_SIZE);

    assign rd_en   = (state_reg == ST_SCAN) && issue_on_reg;
    assign rd_addr = issue_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = didx_reg;
        wr_data = {1'b0, e_key, e_handle};
        if ((state_reg == ST_SCAN) && dv_reg)
        begin
            if ((mode_reg == kst_pkg::MODE_INSERT) && !e_valid)
            begin
                wr_en   = 1'b1;
                wr_data = {1'b1, key_reg, hin_reg};
            end
            else if ((mode_reg == kst_pkg::MODE_REMOVE) && e_match)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= kst_pkg::MODE_LOOKUP;
            key_reg        <= '0;
            hin_reg        <= '0;
            issue_reg      <= '0;
            issue_on_reg   <= 1'b0;
            dv_reg         <= 1'b0;
            didx_reg       <= '0;
            hit_reg        <= 1'b0;
            lh_reg         <= '0;
            ls_reg         <= '0;
            done_reg       <= 1'b0;
            status_reg     <= kst_pkg::STATUS_OK;
            handle_out_reg <= '0;
            slot_out_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    dv_reg       <= 1'b0;
                    issue_on_reg <= 1'b0;
                    if (start && !init.active)
                    begin
                        mode_reg <= kst_pkg::mode_t'(mode);
                        key_reg  <= key;
                        hin_reg  <= handle_in;
                        hit_reg  <= 1'b0;
                        if (kst_pkg::mode_t'(mode) == kst_pkg::MODE_READ)
                        begin
                            if (slot_in_range)
                            begin
                                issue_reg    <= slot_ext[AW-1:0];
                                issue_on_reg <= 1'b1;
                                state_reg    <= ST_SCAN;
                            end
                            else
                            begin
                                done_reg       <= 1'b1;
                                status_reg     <= kst_pkg::STATUS_FAIL;
                                handle_out_reg <= '0;
                                slot_out_reg   <= '0;
                            end
                        end
                        else
                        begin
                            issue_reg    <= '0;
                            issue_on_reg <= 1'b1;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    dv_reg   <= issue_on_reg;
                    didx_reg <= issue_reg;
                    if (issue_on_reg)
                    begin
                        if (issue_stop)
                        begin
                            issue_on_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_reg <= issue_reg + 1'b1;
                        end
                    end
                    if (dv_reg)
                    begin
                        case (mode_reg)
                            kst_pkg::MODE_LOOKUP, kst_pkg::MODE_READ:
                            begin
                                if ((mode_reg == kst_pkg::MODE_READ) ? e_valid : e_match)
                                begin
                                    state_reg      <= ST_IDLE;
                                    issue_on_reg   <= 1'b0;
                                    dv_reg         <= 1'b0;
                                    done_reg       <= 1'b1;
                                    status_reg     <= kst_pkg::STATUS_OK;
                                    handle_out_reg <= e_handle;
                                    slot_out_reg   <= slot5(didx_reg);
                                end
                                else if (last)
                                begin
                                    state_reg      <= ST_IDLE;
                                    issue_on_reg   <= 1'b0;
                                    dv_reg         <= 1'b0;
                                    done_reg       <= 1'b1;
                                    status_reg     <= kst_pkg::STATUS_FAIL;
                                    handle_out_reg <= '0;
                                    slot_out_reg   <= '0;
                                end
                            end
                            kst_pkg::MODE_INSERT:
                            begin
                                if (!e_valid)
                                begin
                                    state_reg      <= ST_IDLE;
                                    issue_on_reg   <= 1'b0;
                                    dv_reg         <= 1'b0;
                                    done_reg       <= 1'b1;
                                    status_reg     <= kst_pkg::STATUS_OK;
                                    handle_out_reg <= hin_reg;
                                    slot_out_reg   <= slot5(didx_reg);
                                end
                                else if (last)
                                begin
                                    state_reg      <= ST_IDLE;
                                    issue_on_reg   <= 1'b0;
                                    dv_reg         <= 1'b0;
                                    done_reg       <= 1'b1;
                                    status_reg     <= kst_pkg::STATUS_FAIL;
                                    handle_out_reg <= '0;
                                    slot_out_reg   <= '0;
                                end
                            end
                            default:
                            begin
                                if (e_match)
                                begin
                                    hit_reg <= 1'b1;
                                    lh_reg  <= e_handle;
                                    ls_reg  <= didx_reg;
                                end
                                if (last)
                                begin
                                    state_reg    <= ST_IDLE;
                                    issue_on_reg <= 1'b0;
                                    dv_reg       <= 1'b0;
                                    done_reg     <= 1'b1;
                                    if (e_match)
                                    begin
                                        status_reg     <= kst_pkg::STATUS_OK;
                                        handle_out_reg <= e_handle;
                                        slot_out_reg   <= slot5(didx_reg);
                                    end
                                    else if (hit_reg)
                                    begin
                                        status_reg     <= kst_pkg::STATUS_OK;
                                        handle_out_reg <= lh_reg;
                                        slot_out_reg   <= slot5(ls_reg);
                                    end
                                    else
                                    begin
                                        status_reg     <= kst_pkg::STATUS_FAIL;
                                        handle_out_reg <= '0;
                                        slot_out_reg   <= '0;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE) || init.active;
    assign done       = done_reg;
    assign status     = status_reg;
    assign handle_out = handle_out_reg;
    assign slot_out   = slot_out_reg;

endmodule

FILE: rtl/core/keyed_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_slot_table
// slot table with key lookup, read by slot, first-free insert and remove
//
// channel   signals                                   handshake
// request   mode, key, slot_in, handle_in             start high, busy low
// result    status, handle_out, slot_out              done strobe, one cycle
//
// lookup: the scan runs from slot 0 and stops at the first matching slot
// lookup miss, insert, remove: scan up to the last slot, reading the
//   table memory one entry per cycle
// read by slot: reads that slot in range, fails without a read out of range
// after reset a clearing pass over every entry holds busy high
// results cannot be stalled; busy is low in the cycle the strobe is shown
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyed_slot_table #(
    parameter int TABLE_SIZE  = kst_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS    = kst_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = kst_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    mode,
    input  logic [KEY_BITS-1:0]           key,
    input  logic [kst_pkg::SLOT_BITS-1:0] slot_in,
    input  logic [HANDLE_BITS-1:0]        handle_in,
    output logic                          done,
    output logic                          status,
    output logic [HANDLE_BITS-1:0]        handle_out,
    output logic [kst_pkg::SLOT_BITS-1:0] slot_out
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int EW = KEY_BITS + HANDLE_BITS + 1;

    kst_pkg::init_t init;
    logic [AW-1:0]  clr_addr;

    logic           eng_rd_en;
    logic [AW-1:0]  eng_rd_addr;
    logic [EW-1:0]  ram_rdata;
    logic           eng_wr_en;
    logic [AW-1:0]  eng_wr_addr;
    logic [EW-1:0]  eng_wr_data;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata;

    kst_init #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_init (
        .clk   (clk),
        .rst_n (rst_n),
        .init  (init),
        .addr  (clr_addr)
    );

    kst_engine #(
        .TABLE_SIZE  (TABLE_SIZE),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (init),
        .start      (start),
        .mode       (mode),
        .key        (key),
        .slot_in    (slot_in),
        .handle_in  (handle_in),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .handle_out (handle_out),
        .slot_out   (slot_out),
        .rd_en      (eng_rd_en),
        .rd_addr    (eng_rd_addr),
        .rd_data    (ram_rdata),
        .wr_en      (eng_wr_en),
        .wr_addr    (eng_wr_addr),
        .wr_data    (eng_wr_data)
    );

    // clearing pass owns the write port until it ends
    assign ram_we    = init.wr_en || eng_wr_en;
    assign ram_waddr = init.wr_en ? clr_addr : eng_wr_addr;
    assign ram_wdata = init.wr_en ? '0 : eng_wr_data;

    kst_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (eng_rd_en),
        .raddr (eng_rd_addr),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/core/kst_checker.sv
// ----------------------------------------------------------------------------
// kst_checker
// port-level checks of the keyed slot table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyed_slot_table_defines.svh"

module kst_checker #(
    parameter int TABLE_SIZE  = kst_pkg::TABLE_SIZE_DEF,
    parameter int HANDLE_BITS = kst_pkg::HANDLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    mode,
    input logic [kst_pkg::SLOT_BITS-1:0] slot_in,
    input logic                          done,
    input logic                          status,
    input logic [HANDLE_BITS-1:0]        handle_out,
    input logic [kst_pkg::SLOT_BITS-1:0] slot_out
);

    logic accept;
    logic read_oor;
    logic fail_strobe;
    logic fail_clean;

    assign accept      = start && !busy;
    assign read_oor    = (mode == 2'(kst_pkg::MODE_READ))
                         && (32'(slot_in) >= 32'(TABLE_SIZE));
    assign fail_strobe = done && (status == kst_pkg::STATUS_FAIL);
    assign fail_clean  = (handle_out == '0) && (slot_out == '0);

    `KST_ASSERT_IMPL(a_fail_zero, fail_strobe, fail_clean)
    `KST_ASSERT_NEXT(a_accept_busy, accept, busy || done)
    `KST_ASSERT_IMPL(a_done_after_request, done, $past(accept) || $past(busy))
    `KST_ASSERT_NEXT(a_read_oor_fails, accept && read_oor, fail_strobe)

endmodule

bind keyed_slot_table kst_checker #(
    .TABLE_SIZE  (TABLE_SIZE),
    .HANDLE_BITS (HANDLE_BITS)
) u_kst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .slot_in    (slot_in),
    .done       (done),
    .status     (status),
    .handle_out (handle_out),
    .slot_out   (slot_out)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of the keyed slot table: drives lookup, read, insert and remove
// requests, predicts every result from its own copy of the table and
// compares each strobed result with the oldest prediction
// ----------------------------------------------------------------------------

module tb;
    import kst_pkg::*;

    localparam int NSLOT        = TABLE_SIZE_DEF;
    localparam int KW           = KEY_BITS_DEF;
    localparam int HW           = HANDLE_BITS_DEF;
    localparam int RANDOM_ITEMS = 1600;
    localparam int TAIL_ITEMS   = 200;
    localparam int DRAIN_CYCLES = NSLOT + 8;
    localparam int WAIT_LIMIT   = 4 * NSLOT + 100;

    typedef enum int {
        PHASE_MIXED,
        PHASE_FILL,
        PHASE_DRAIN
    } phase_t;

    typedef struct {
        logic                 status;
        logic [HW-1:0]        handle;
        logic [SLOT_BITS-1:0] slot;
    } table_result_t;

    class slot_table_scoreboard;
        bit                   occupied [NSLOT];
        logic [KW-1:0]        stored_key [NSLOT];
        logic [HW-1:0]        stored_handle [NSLOT];
        table_result_t        pending [$];
        int                   mismatches;
        int                   checked;
        int                   op_count [4];
        int                   fail_count [4];
        int                   full_inserts;
        int                   multi_removes;

        function new();
            int i;
            for (i = 0; i < NSLOT; i++)
            begin
                occupied[i]      = 1'b0;
                stored_key[i]    = '0;
                stored_handle[i] = '0;
            end
            for (i = 0; i < 4; i++)
            begin
                op_count[i]   = 0;
                fail_count[i] = 0;
            end
            mismatches    = 0;
            checked       = 0;
            full_inserts  = 0;
            multi_removes = 0;
        endfunction

        function void note_request(mode_t op, logic [KW-1:0] k, logic [SLOT_BITS-1:0] sl,
                                   logic [HW-1:0] h);
            table_result_t r;
            bit            hit;
            int            i;
            int            cleared;
            r.status = STATUS_FAIL;
            r.handle = '0;
            r.slot   = '0;
            hit      = 1'b0;
            cleared  = 0;
            case (op)
                MODE_LOOKUP:
                begin
                    for (i = 0; i < NSLOT; i++)
                    begin
                        if (!hit && occupied[i] && stored_key[i] == k)
                        begin
                            hit      = 1'b1;
                            r.status = STATUS_OK;
                            r.handle = stored_handle[i];
                            r.slot   = i[SLOT_BITS-1:0];
                        end
                    end
                end
                MODE_READ:
                begin
                    if (int'(sl) < NSLOT && occupied[sl])
                    begin
                        r.status = STATUS_OK;
                        r.handle = stored_handle[sl];
                        r.slot   = sl;
                    end
                end
                MODE_INSERT:
                begin
                    for (i = 0; i < NSLOT; i++)
                    begin
                        if (!hit && !occupied[i])
                        begin
                            hit              = 1'b1;
                            occupied[i]      = 1'b1;
                            stored_key[i]    = k;
                            stored_handle[i] = h;
                            r.status         = STATUS_OK;
                            r.handle         = h;
                            r.slot           = i[SLOT_BITS-1:0];
                        end
                    end
                    if (!hit)
                        full_inserts++;
                end
                default:
                begin
                    for (i = 0; i < NSLOT; i++)
                    begin
                        if (occupied[i] && stored_key[i] == k)
                        begin
                            cleared++;
                            occupied[i] = 1'b0;
                            r.status    = STATUS_OK;
                            r.handle    = stored_handle[i];
                            r.slot      = i[SLOT_BITS-1:0];
                        end
                    end
                    if (cleared > 1)
                        multi_removes++;
                end
            endcase
            op_count[op]++;
            if (r.status == STATUS_FAIL)
                fail_count[op]++;
            pending.push_back(r);
        endfunction

        function void check_result(logic st, logic [HW-1:0] h, logic [SLOT_BITS-1:0] s);
            table_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request waiting:", $realtime,
                             " status %0b handle %h slot %0d", st, h, s);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (st !== e.status || h !== e.handle || s !== e.slot)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d: expected status %0b handle %h slot %0d,",
                             $realtime, checked, e.status, e.handle, e.slot,
                             " got status %0b handle %h slot %0d", st, h, s);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           mode;
    logic [KW-1:0]        key;
    logic [SLOT_BITS-1:0] slot_in;
    logic [HW-1:0]        handle_in;
    logic                 done;
    logic                 status;
    logic [HW-1:0]        handle_out;
    logic [SLOT_BITS-1:0] slot_out;

    slot_table_scoreboard board;

    keyed_slot_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .key        (key),
        .slot_in    (slot_in),
        .handle_in  (handle_in),
        .done       (done),
        .status     (status),
        .handle_out (handle_out),
        .slot_out   (slot_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // results first: a new request can be taken at the edge that ends a strobe
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
                board.check_result(status, handle_out, slot_out);
            if (start === 1'b1 && busy === 1'b0)
                board.note_request(mode_t'(mode), key, slot_in, handle_in);
        end
    end

    task automatic issue(mode_t op, logic [KW-1:0] k, logic [SLOT_BITS-1:0] sl,
                         logic [HW-1:0] h);
        @(negedge clk);
        start     <= 1'b1;
        mode      <= op;
        key       <= k;
        slot_in   <= sl;
        handle_in <= h;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // idle cycles with junk on the request fields
    task automatic pause(int n);
        repeat (n)
        begin
            @(negedge clk);
            start     <= 1'b0;
            mode      <= 2'($urandom_range(0, 3));
            key       <= KW'($urandom);
            slot_in   <= SLOT_BITS'($urandom);
            handle_in <= HW'($urandom);
        end
    endtask

    // small pool so that lookups and removes hit and duplicates pile up
    function automatic logic [KW-1:0] pick_key();
        logic [KW-1:0] pool [8];
        pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                 16'h5A5A, 16'h00FF, 16'h1234, 16'hABCD};
        if ($urandom_range(0, 99) < 85)
            return pool[$urandom_range(0, 7)];
        return KW'($urandom);
    endfunction

    function automatic logic [HW-1:0] pick_handle();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return HW'($urandom);
    endfunction

    task automatic random_item(phase_t kind, bit gaps);
        int    roll;
        mode_t op;
        roll = $urandom_range(0, 99);
        case (kind)
            PHASE_FILL:
                op = (roll < 65) ? MODE_INSERT : (roll < 80) ? MODE_LOOKUP :
                     (roll < 92) ? MODE_READ : MODE_REMOVE;
            PHASE_DRAIN:
                op = (roll < 55) ? MODE_REMOVE : (roll < 75) ? MODE_LOOKUP :
                     (roll < 90) ? MODE_READ : MODE_INSERT;
            default:
                op = mode_t'(roll % 4);
        endcase
        issue(op, pick_key(), SLOT_BITS'($urandom_range(0, NSLOT - 1)), pick_handle());
        if (gaps && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 10));
    endtask

    initial
    begin
        int     items;
        int     len;
        int     waited;
        phase_t kind;
        board     = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        mode      = MODE_LOOKUP;
        key       = '0;
        slot_in   = '0;
        handle_in = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: misses on an empty table, duplicates, multi-slot remove
        issue(MODE_LOOKUP, 16'h0000, 5'd0, 16'h0000);
        issue(MODE_READ,   16'h0000, 5'd0, 16'h0000);
        issue(MODE_READ,   16'hFFFF, 5'd31, 16'hFFFF);
        issue(MODE_REMOVE, 16'hFFFF, 5'd0, 16'h0000);
        issue(MODE_INSERT, 16'h0000, 5'd0, 16'h0000);
        issue(MODE_INSERT, 16'hFFFF, 5'd31, 16'hFFFF);
        issue(MODE_INSERT, 16'h0000, 5'd0, 16'h1234);
        issue(MODE_LOOKUP, 16'h0000, 5'd0, 16'h0000);
        issue(MODE_LOOKUP, 16'hFFFF, 5'd0, 16'h0000);
        issue(MODE_READ,   16'h0000, 5'd2, 16'h0000);
        issue(MODE_REMOVE, 16'h0000, 5'd0, 16'h0000);
        issue(MODE_LOOKUP, 16'h0000, 5'd0, 16'h0000);
        issue(MODE_READ,   16'h0000, 5'd0, 16'h0000);
        issue(MODE_INSERT, 16'h5A5A, 5'd0, 16'hA5A5);
        issue(MODE_INSERT, 16'hA5A5, 5'd0, 16'h5A5A);
        issue(MODE_REMOVE, 16'hFFFF, 5'd0, 16'h0000);
        issue(MODE_READ,   16'h0000, 5'd1, 16'h0000);
        issue(MODE_LOOKUP, 16'hA5A5, 5'd0, 16'h0000);
        issue(MODE_REMOVE, 16'h5A5A, 5'd0, 16'h0000);
        issue(MODE_REMOVE, 16'hA5A5, 5'd0, 16'h0000);
        pause($urandom_range(1, 10));

        // random phases; the first one is a fill phase, mostly inserts
        items = 0;
        kind  = PHASE_FILL;
        len   = 50;
        while (items < RANDOM_ITEMS - TAIL_ITEMS)
        begin
            repeat (len)
            begin
                random_item(kind, 1'b1);
                items++;
            end
            kind = phase_t'($urandom_range(0, 2));
            len  = $urandom_range(20, 80);
        end
        repeat (TAIL_ITEMS)
            random_item(phase_t'($urandom_range(0, 2)), 1'b0);

        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (board.pending.size() != 0 && waited < WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending.size() != 0)
        begin
            $display("%0d results never arrived", board.pending.size());
            board.mismatches += board.pending.size();
        end

        $display("requests: %0d lookups (%0d missed), %0d reads (%0d empty),",
                 board.op_count[MODE_LOOKUP], board.fail_count[MODE_LOOKUP],
                 board.op_count[MODE_READ], board.fail_count[MODE_READ],
                 " %0d inserts (%0d into a full table)",
                 board.op_count[MODE_INSERT], board.full_inserts);
        $display("removes: %0d (%0d missed, %0d cleared several slots),",
                 board.op_count[MODE_REMOVE], board.fail_count[MODE_REMOVE],
                 board.multi_removes,
                 " results checked %0d, mismatches %0d",
                 board.checked, board.mismatches);
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting on the block");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/kst_ram.sv
rtl/core/kst_init.sv
rtl/core/kst_engine.sv
rtl/core/keyed_slot_table.sv
rtl/core/kst_checker.sv
sim/tb.sv
